[rtl/mnst_pkg.sv]
// ----------------------------------------------------------------------------
// MIDI note state package
// Shared constants, operation codes and types for the note state table with
// sustain pedal.
// ----------------------------------------------------------------------------
package mnst_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int IDX_W      = $clog2(NOTE_COUNT);
  localparam int CNT_W      = $clog2(NOTE_COUNT + 1);
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int OP_W       = 3;
  localparam int CMP_W      = (CNT_W > NOTE_W) ? CNT_W : NOTE_W;
  localparam int ENTRY_W    = VEL_W + 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_NOTE_ON  = 3'd0;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 3'd1;
  localparam logic [OP_W-1:0] OP_PEDAL    = 3'd2;
  localparam logic [OP_W-1:0] OP_ALL_OFF  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

  typedef struct packed {
    logic             held;
    logic             sus;
    logic [VEL_W-1:0] vel;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [VEL_W-1:0] velocity;
    logic             held;
    logic             sustained;
    logic             pedal;
  } result_t;

endpackage

[rtl/mnst_ram.sv]
// ----------------------------------------------------------------------------
// MIDI note state RAM
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module mnst_ram #(
  parameter int WIDTH  = 9,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mnst_ctrl.sv]
// ----------------------------------------------------------------------------
// MIDI note state sequencer
// Reads the addressed entry, applies the operation and writes it back, and
// sweeps the whole table for pedal release, all notes off and after reset.
// ----------------------------------------------------------------------------
module mnst_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mnst_pkg::OP_W-1:0]      in_op,
  input  logic [mnst_pkg::NOTE_W-1:0]    in_note,
  input  logic [mnst_pkg::VEL_W-1:0]     in_vel,
  input  logic                           in_ped,
  output mnst_pkg::mem_req_t             mem_req,
  input  mnst_pkg::entry_t               mem_rdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output mnst_pkg::result_t              res
);
  import mnst_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pv_r, pv_nxt;
  logic [IDX_W-1:0] pa_r, pa_nxt;
  logic             clr_all_r, clr_all_nxt;
  logic             pedal_r, pedal_nxt;
  logic [OP_W-1:0]  op_r;
  logic [VEL_W-1:0] vel_r;
  logic             ped_r;
  logic             in_range_r;
  result_t          res_r, res_nxt;
  entry_t           cur;
  entry_t           upd;
  logic             in_accept;
  logic             in_range;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign in_range  = CMP_W'(in_note) < CMP_W'(NOTE_COUNT);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // An absent entry reads as all zeros whatever the RAM holds.
  always_comb begin
    cur = '0;
    if (in_range_r && mem_rdata.held) begin
      cur = mem_rdata;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pv_nxt      = 1'b0;
    pa_nxt      = pa_r;
    clr_all_nxt = clr_all_r;
    pedal_nxt   = pedal_r;
    res_nxt     = res_r;
    mem_req     = '0;
    upd         = cur;
    unique case (state_r)
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r[IDX_W-1:0];
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NOTE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_req.re    = in_accept;
        mem_req.raddr = IDX_W'(in_note);
        if (in_accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt   = S_DONE;
        cnt_nxt     = '0;
        clr_all_nxt = 1'b0;
        unique case (op_r)
          OP_NOTE_ON: begin
            if (in_range_r) begin
              upd           = '{held: 1'b1, sus: 1'b0, vel: vel_r};
              mem_req.we    = 1'b1;
              mem_req.waddr = pa_r;
              mem_req.wdata = upd;
            end
          end
          OP_NOTE_OFF: begin
            if (cur.held) begin
              upd           = pedal_r ? entry_t'{held: 1'b1, sus: 1'b1, vel: cur.vel} : '0;
              mem_req.we    = 1'b1;
              mem_req.waddr = pa_r;
              mem_req.wdata = upd;
            end
          end
          OP_PEDAL: begin
            if (ped_r != pedal_r) begin
              pedal_nxt = ped_r;
              if (!ped_r) begin
                state_nxt = S_SWEEP;
                if (cur.sus) begin
                  upd = '0;
                end
              end
            end
          end
          OP_ALL_OFF: begin
            pedal_nxt   = 1'b0;
            clr_all_nxt = 1'b1;
            state_nxt   = S_SWEEP;
            upd         = '0;
          end
          default: begin
          end
        endcase
        res_nxt = '{velocity: upd.vel, held: upd.held, sustained: upd.sus,
                    pedal: pedal_nxt};
      end
      S_SWEEP: begin
        // Read one entry a cycle; in the next cycle free the entry just read if it is sustaining or all notes are off.
        mem_req.re    = cnt_r < CNT_W'(NOTE_COUNT);
        mem_req.raddr = cnt_r[IDX_W-1:0];
        if (pv_r && (clr_all_r || (mem_rdata.held && mem_rdata.sus))) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pa_r;
        end
        pv_nxt = mem_req.re;
        pa_nxt = mem_req.raddr;
        if (mem_req.re) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (!pv_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (state_r == S_IDLE && in_accept) begin
      pa_nxt = IDX_W'(in_note);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      cnt_r     <= '0;
      pv_r      <= 1'b0;
      clr_all_r <= 1'b0;
      pedal_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pv_r      <= pv_nxt;
      clr_all_r <= clr_all_nxt;
      pedal_r   <= pedal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r  <= pa_nxt;
    res_r <= res_nxt;
    if (in_accept) begin
      op_r       <= in_op;
      vel_r      <= in_vel;
      ped_r      <= in_ped;
      in_range_r <= in_range;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_req.we)
    else $error("table written while idle");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_READ))
    else $error("accepted transaction did not move to the read step");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.held || (res.velocity == '0 && !res.sustained)))
    else $error("absent note reported with state");

  a_sus_pedal: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.sustained) |-> res.pedal)
    else $error("sustained note reported with pedal up");
`endif

endmodule

[rtl/midi_note_state_sustain_table.sv]
// ----------------------------------------------------------------------------
// MIDI note state table with sustain pedal
// Per-note held, sustaining and velocity state in a RAM, with a pedal
// register, and one result transaction for each input transaction.
// ----------------------------------------------------------------------------
// Each transaction is read from the note RAM in the cycle after acceptance,
// updated and written back. Its result passes the controller's result
// register and then the output register on its way to out_tvalid, and
// in_tready rises again in the same cycle as out_tvalid. A pedal release and
// all notes off also sweep the RAM, one entry a cycle, before the result is
// given. After reset the block clears the RAM before in_tready first rises.
// The next transaction is accepted while a result still waits on the output;
// a second finished result holds the block until the output register is
// taken.
module midi_note_state_sustain_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [6:0] note, [13:7] velocity, [14] pedal, [15] zero
  input  logic [mnst_pkg::IN_DATA_W-1:0]      in_tdata,
  // [2:0] op
  input  logic [mnst_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [6:0] note_velocity, [7] note_held, [8] note_sustained, [9] pedal_down,
  // [15:10] zero
  output logic [mnst_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import mnst_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  logic     out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  mnst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_note   (in_tdata[6:0]),
    .in_vel    (in_tdata[13:7]),
    .in_ped    (in_tdata[14]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  mnst_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (NOTE_COUNT),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {6'd0, res.pedal, res.sustained, res.held, res.velocity};
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for the MIDI note state table with sustain pedal
// Drives note on, note off, pedal, all notes off, query and spare operation
// transactions with random idle gaps on both channels. A software copy of
// the note table predicts each result transaction, and every result is
// compared field by field with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mnst_pkg::*;

  localparam int                LIMIT_CYCLES   = 1_000_000;
  localparam int                DRAIN_CYCLES   = 150;
  localparam int                RANDOM_EVENTS  = 1530;
  localparam int                MAX_WAIT       = 14;
  localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic              pedal;
  } midi_evt_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  midi_evt_t evt_backlog[$];
  result_t   expected_reports[$];
  midi_evt_t cur_evt;

  // Predicted note table and pedal.
  entry_t    note_state [NOTE_COUNT];
  logic      pedal_now;

  logic [NOTE_W-1:0] hot_notes [8];

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  bit   calm_in = 1'b0;
  bit   calm_out = 1'b0;

  int   cycle_count = 0;
  int   events_sent = 0;
  int   reports_seen = 0;
  int   sustained_seen = 0;
  int   sweeps_seen = 0;
  int   mismatches = 0;

  midi_note_state_sustain_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Applies one transaction to the predicted table and returns the report
  // that the block should give for the addressed note afterwards.
  function automatic result_t track_note_event(midi_evt_t ev);
    int      k;
    bit      in_range;
    result_t rpt;
    k = int'(ev.note);
    in_range = k < NOTE_COUNT;
    unique case (ev.op)
      OP_NOTE_ON: begin
        if (in_range) note_state[k] = '{held: 1'b1, sus: 1'b0, vel: ev.velocity};
      end
      OP_NOTE_OFF: begin
        if (in_range && note_state[k].held) begin
          if (pedal_now) note_state[k].sus = 1'b1;
          else note_state[k] = '0;
        end
      end
      OP_PEDAL: begin
        if (ev.pedal != pedal_now) begin
          pedal_now = ev.pedal;
          if (!ev.pedal) begin
            sweeps_seen++;
            for (int i = 0; i < NOTE_COUNT; i++)
              if (note_state[i].held && note_state[i].sus) note_state[i] = '0;
          end
        end
      end
      OP_ALL_OFF: begin
        pedal_now = 1'b0;
        sweeps_seen++;
        for (int i = 0; i < NOTE_COUNT; i++) note_state[i] = '0;
      end
      default: ;
    endcase
    if (in_range && note_state[k].held) begin
      rpt.velocity  = note_state[k].vel;
      rpt.held      = 1'b1;
      rpt.sustained = note_state[k].sus;
    end else begin
      rpt.velocity  = '0;
      rpt.held      = 1'b0;
      rpt.sustained = 1'b0;
    end
    rpt.pedal = pedal_now;
    return rpt;
  endfunction

  task automatic queue_event(logic [OP_W-1:0] op, int note, int vel, bit ped);
    midi_evt_t ev;
    ev.op       = op;
    ev.note     = NOTE_W'(note);
    ev.velocity = VEL_W'(vel);
    ev.pedal    = ped;
    evt_backlog = {evt_backlog, ev};
  endtask

  // Random traffic mostly plays on a small set of keys so that note off and
  // pedal release find held and sustaining entries.
  task automatic queue_random_events(int count);
    int        r;
    midi_evt_t ev;
    for (int i = 0; i < 8; i++) hot_notes[i] = NOTE_W'($urandom_range(0, 127));
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) hot_notes[$urandom_range(0, 7)] = NOTE_W'($urandom_range(0, 127));
      r = $urandom_range(0, 99);
      if (r < 32) ev.op = OP_NOTE_ON;
      else if (r < 57) ev.op = OP_NOTE_OFF;
      else if (r < 72) ev.op = OP_PEDAL;
      else if (r < 74) ev.op = OP_ALL_OFF;
      else if (r < 96) ev.op = OP_QUERY;
      else ev.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      if ($urandom_range(0, 3) != 0) ev.note = hot_notes[$urandom_range(0, 7)];
      else ev.note = NOTE_W'($urandom_range(0, 127));
      ev.velocity = VEL_W'($urandom_range(0, 127));
      ev.pedal    = 1'($urandom_range(0, 1));
      evt_backlog = {evt_backlog, ev};
    end
  endtask

  // Input driver: a new transaction is presented at the falling edge once
  // the previous one has been taken and its idle gap has run out.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_took)) begin
      if (in_tvalid) in_gap = draw_wait(calm_in);
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (evt_backlog.size() > 0) begin
        cur_evt = evt_backlog.pop_front();
        in_tdata  <= {1'b0, cur_evt.pedal, cur_evt.velocity, cur_evt.note};
        in_tuser  <= cur_evt.op;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, drawn afresh after every accepted result.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_took) out_gap = draw_wait(calm_out);
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each input transaction and checks each result.
  always @(posedge clk) begin
    result_t want;
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_reports = {expected_reports, track_note_event(cur_evt)};
      events_sent++;
      if (events_sent % 50 == 0) calm_in = ($urandom_range(0, 3) == 0);
    end
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen++;
      if (reports_seen % 50 == 0) calm_out = ($urandom_range(0, 3) == 0);
      if (expected_reports.size() == 0) begin
        $error("unexpected result transaction: out_tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (want.sustained) sustained_seen++;
        if (out_tdata[6:0] !== want.velocity) begin
          $error("note_velocity: expected %0d, got %0d", want.velocity, out_tdata[6:0]);
          mismatches++;
        end
        if (out_tdata[7] !== want.held) begin
          $error("note_held: expected %0d, got %0d", want.held, out_tdata[7]);
          mismatches++;
        end
        if (out_tdata[8] !== want.sustained) begin
          $error("note_sustained: expected %0d, got %0d", want.sustained, out_tdata[8]);
          mismatches++;
        end
        if (out_tdata[9] !== want.pedal) begin
          $error("pedal_down: expected %0d, got %0d", want.pedal, out_tdata[9]);
          mismatches++;
        end
        if (out_tdata[15:10] !== '0) begin
          $error("padding: expected 0, got %h", out_tdata[15:10]);
          mismatches++;
        end
      end
    end
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_reports.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NOTE_COUNT; i++) note_state[i] = '0;
    pedal_now = 1'b0;

    // Directed part: empty table, velocity extremes, sustain and release.
    queue_event(OP_QUERY,    0,   127, 1'b1);  // absent note after reset
    queue_event(OP_NOTE_ON,  0,   0,   1'b0);  // a zero velocity is still stored
    queue_event(OP_NOTE_ON,  127, 127, 1'b1);
    queue_event(OP_NOTE_OFF, 127, 5,   1'b1);  // pedal up: entry freed
    queue_event(OP_PEDAL,    10,  0,   1'b1);
    queue_event(OP_PEDAL,    10,  0,   1'b1);  // same pedal state: no change
    queue_event(OP_NOTE_ON,  60,  100, 1'b0);
    queue_event(OP_NOTE_OFF, 60,  0,   1'b0);  // pedal down: sustaining
    queue_event(OP_NOTE_OFF, 60,  0,   1'b0);
    queue_event(OP_NOTE_OFF, 5,   0,   1'b0);  // note not held
    queue_event(OP_NOTE_ON,  60,  1,   1'b0);  // re-strike clears sustaining
    queue_event(OP_NOTE_OFF, 60,  0,   1'b0);
    queue_event(OP_QUERY,    60,  0,   1'b0);
    queue_event(OP_PEDAL,    60,  0,   1'b0);  // release frees note 60
    queue_event(OP_QUERY,    0,   0,   1'b0);  // note 0 kept, never sustaining
    queue_event(OP_NOTE_OFF, 0,   0,   1'b0);
    queue_event(OP_PEDAL,    1,   0,   1'b1);
    queue_event(OP_PEDAL,    1,   0,   1'b0);  // release with nothing sustaining
    queue_event(OP_PEDAL,    33,  0,   1'b1);
    queue_event(OP_NOTE_ON,  33,  64,  1'b0);
    queue_event(OP_NOTE_ON,  34,  65,  1'b1);
    queue_event(OP_NOTE_OFF, 34,  0,   1'b0);
    queue_event(OP_ALL_OFF,  33,  127, 1'b1);  // pedal goes up, table cleared
    queue_event(OP_SPARE_FIRST, 0, 127, 1'b1);
    queue_event(OP_SPARE_LAST, 127, 0, 1'b1);
    queue_random_events(RANDOM_EVENTS);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (evt_backlog.size() != 0 || in_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_reports.size() != 0) begin
      $error("%0d predicted results never arrived", expected_reports.size());
      mismatches++;
    end
    $display("%0d transactions checked in %0d cycles; %0d reports showed a sustained note,",
             reports_seen, cycle_count, sustained_seen);
    $display("%0d table sweeps by pedal release or all notes off; %0d mismatches",
             sweeps_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mnst_pkg.sv
rtl/mnst_ram.sv
rtl/mnst_ctrl.sv
rtl/midi_note_state_sustain_table.sv
bench/testbench.sv
